/* src/edk_pkg.sv */
// ----------------------------------------------------------------------------
// edk_pkg
// Shared types and constants of the max-flow unit: edge item, queue entry and
// the status group that flows from the solver back to the loader.
// ----------------------------------------------------------------------------
package edk_pkg;

	localparam int NODE_FW = 7;
	localparam int CAP_W   = 16;
	localparam int RES_W   = 17;
	localparam int FLOW_W  = 23;
	localparam int NCNT_W  = 9;
	localparam int QDEPTH  = 4;
	localparam int QPW     = $clog2(QDEPTH);

	localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [1:0] CFG_SOURCE     = 2'd1;
	localparam logic [1:0] CFG_SINK       = 2'd2;

	typedef struct packed {
		logic [NODE_FW-1:0] from_node;
		logic [NODE_FW-1:0] to_node;
		logic [CAP_W-1:0]   capacity;
		logic               wr;
		logic               last;
	} edk_item_t;

	typedef struct packed {
		logic      valid;
		edk_item_t item;
	} edk_fwd_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} edk_ret_t;

endpackage

/* src/max_flow_edmonds_karp_unit.sv */
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp_unit
// Maximum flow by shortest augmenting paths over a residual capacity matrix.
//
// Usage: write node_count, source_node and sink_node on the cfg channel
// (cfg_ready is always high) while idle. Present one edge per cycle with
// start; an edge is taken at each edge where start is high and busy is low.
// All edges pass through a four-entry queue. The edge with last_edge
// set triggers the solver: it repeats breadth-first searches and walks and
// augments each found path; the total is on max_flow with done high for
// one cycle. After each result, and after reset, a clearing pass sweeps
// the residual memory with busy high.
// Edges sent while the solver runs wait in the queue; busy rises when it is
// full. The receiver takes the result in its single cycle, no stall exists.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp_unit #(
	parameter int MAX_NODES = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [edk_pkg::NODE_FW-1:0]   from_node,
	input  logic [edk_pkg::NODE_FW-1:0]   to_node,
	input  logic [edk_pkg::CAP_W-1:0]     capacity,
	input  logic                          last_edge,
	output logic [edk_pkg::FLOW_W-1:0]    max_flow,
	output logic                          done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [7:0]                    cfg_data
);
	import edk_pkg::*;

	logic [7:0]         node_count_q;
	logic [NODE_FW-1:0] source_q, sink_q;
	logic [NCNT_W-1:0]  eff_n;
	edk_fwd_t           fwd;
	edk_ret_t           ret;

	assign cfg_ready = 1'b1;
	assign eff_n = ({1'b0, node_count_q} > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES)
		: {1'b0, node_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 8'd128;
			source_q     <= '0;
			sink_q       <= 7'd127;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_NODE_COUNT: node_count_q <= cfg_data;
				CFG_SOURCE:     source_q     <= cfg_data[NODE_FW-1:0];
				CFG_SINK:       sink_q       <= cfg_data[NODE_FW-1:0];
				default: begin
				end
			endcase
		end
	end

	edk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.from_node (from_node),
		.to_node   (to_node),
		.capacity  (capacity),
		.last_edge (last_edge),
		.eff_n     (eff_n),
		.fwd       (fwd),
		.ret       (ret)
	);

	edk_back #(
		.MAX_NODES (MAX_NODES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fwd      (fwd),
		.ret      (ret),
		.eff_n    (eff_n),
		.src      (source_q),
		.dst      (sink_q),
		.max_flow (max_flow),
		.done     (done)
	);

endmodule

/* src/edk_front.sv */
// ----------------------------------------------------------------------------
// edk_front
// Accepts edge items, marks those inside the node range for storage and
// holds them in a short queue for the solver.
// ----------------------------------------------------------------------------
module edk_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [edk_pkg::NODE_FW-1:0]   from_node,
	input  logic [edk_pkg::NODE_FW-1:0]   to_node,
	input  logic [edk_pkg::CAP_W-1:0]     capacity,
	input  logic                          last_edge,
	input  logic [edk_pkg::NCNT_W-1:0]    eff_n,
	output edk_pkg::edk_fwd_t             fwd,
	input  edk_pkg::edk_ret_t             ret
);
	import edk_pkg::*;

	edk_item_t      q_q [QDEPTH];
	logic [QPW-1:0] wp_q, rp_q;
	logic [QPW:0]   cnt_q;
	logic           push, pop;
	edk_item_t      new_item;

	assign busy = (cnt_q == (QPW+1)'(QDEPTH)) || ret.clearing;
	assign push = start && !busy;
	assign pop  = ret.pop && (cnt_q != '0);

	always_comb begin
		new_item.from_node = from_node;
		new_item.to_node   = to_node;
		new_item.capacity  = capacity;
		new_item.wr        = ({2'b00, from_node} < eff_n) && ({2'b00, to_node} < eff_n);
		new_item.last      = last_edge;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign fwd.valid = (cnt_q != '0);
	assign fwd.item  = q_q[rp_q];

endmodule

/* src/edk_back.sv */
// ----------------------------------------------------------------------------
// edk_back
// Residual matrix memory and the augmenting path sequencer: breadth-first
// search, bottleneck walk, residual update, result and clearing pass.
// ----------------------------------------------------------------------------
module edk_back #(
	parameter int MAX_NODES = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  edk_pkg::edk_fwd_t             fwd,
	output edk_pkg::edk_ret_t             ret,
	input  logic [edk_pkg::NCNT_W-1:0]    eff_n,
	input  logic [edk_pkg::NODE_FW-1:0]   src,
	input  logic [edk_pkg::NODE_FW-1:0]   dst,
	output logic [edk_pkg::FLOW_W-1:0]    max_flow,
	output logic                          done
);
	import edk_pkg::*;

	localparam int NW    = $clog2(MAX_NODES);
	localparam int CW    = NW + 1;
	localparam int AW    = 2 * NW;
	localparam int DEPTH = 1 << AW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_BFS_INIT, S_POP, S_POPW, S_SCAN_RD, S_SCAN_CHK,
		S_WALK_P, S_WALK_M, S_WALK_C, S_AUG_P, S_AUG_M, S_AUG_F, S_AUG_B
	} state_t;

	state_t              state_q;
	logic [RES_W-1:0]    mem [DEPTH];
	logic [RES_W-1:0]    mem_rd_q;
	logic [NW-1:0]       pred_mem [MAX_NODES];
	logic [NW-1:0]       pred_rd_q;
	logic [NW-1:0]       sq_mem [MAX_NODES];
	logic [NW-1:0]       sq_rd_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [CW-1:0]       head_q, tail_q, i_q;
	logic [NW-1:0]       u_q, v_q;
	logic [RES_W-1:0]    bott_q;
	logic [FLOW_W-1:0]   flow_q, max_q;
	logic                done_q;
	logic [AW-1:0]       clr_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [RES_W-1:0]    mem_wdata;
	logic                pred_we, sq_we;
	logic [NW-1:0]       sq_waddr, sq_wdata;
	logic [NW-1:0]       src_n, dst_n, iv, in_from, in_to;
	logic                degenerate;

	assign src_n   = NW'(src);
	assign dst_n   = NW'(dst);
	assign iv      = i_q[NW-1:0];
	assign in_from = NW'(fwd.item.from_node);
	assign in_to   = NW'(fwd.item.to_node);
	assign degenerate = (eff_n < NCNT_W'(2)) || (NCNT_W'(src) >= eff_n)
		|| (NCNT_W'(dst) >= eff_n) || (src == dst);

	assign ret.pop      = (state_q == S_IDLE) && fwd.valid;
	assign ret.clearing = (state_q == S_CLEAR);
	assign max_flow     = max_q;
	assign done         = done_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {u_q, v_q};
		mem_wdata = '0;
		mem_raddr = {u_q, iv};
		pred_we   = 1'b0;
		sq_we     = 1'b0;
		sq_waddr  = tail_q[NW-1:0];
		sq_wdata  = iv;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_IDLE: begin
				mem_we    = fwd.valid && fwd.item.wr;
				mem_waddr = {in_from, in_to};
				mem_wdata = RES_W'(fwd.item.capacity);
			end
			S_BFS_INIT: begin
				sq_we    = 1'b1;
				sq_waddr = '0;
				sq_wdata = src_n;
			end
			S_SCAN_CHK: begin
				if (!visited_q[iv] && (mem_rd_q != '0)) begin
					pred_we = 1'b1;
					sq_we   = (iv != dst_n) && (tail_q < CW'(MAX_NODES));
				end
			end
			S_WALK_M, S_AUG_M: begin
				mem_raddr = {pred_rd_q, v_q};
			end
			S_AUG_F: begin
				mem_we    = 1'b1;
				mem_waddr = {u_q, v_q};
				mem_wdata = mem_rd_q - bott_q;
				mem_raddr = {v_q, u_q};
			end
			S_AUG_B: begin
				mem_we    = 1'b1;
				mem_waddr = {v_q, u_q};
				mem_wdata = mem_rd_q + bott_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rd_q <= mem[mem_raddr];
		if (pred_we) begin
			pred_mem[iv] <= u_q;
		end
		pred_rd_q <= pred_mem[v_q];
		if (sq_we) begin
			sq_mem[sq_waddr] <= sq_wdata;
		end
		sq_rd_q <= sq_mem[head_q[NW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			visited_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			i_q       <= '0;
			u_q       <= '0;
			v_q       <= '0;
			bott_q    <= '0;
			flow_q    <= '0;
			max_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= ((state_q == S_IDLE) && fwd.valid && fwd.item.last && degenerate)
				|| ((state_q == S_POP) && (head_q == tail_q));
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (fwd.valid && fwd.item.last) begin
						flow_q <= '0;
						if (degenerate) begin
							max_q   <= '0;
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_BFS_INIT;
						end
					end
				end
				S_BFS_INIT: begin
					visited_q <= MAX_NODES'(1) << src_n;
					head_q    <= '0;
					tail_q    <= CW'(1);
					state_q   <= S_POP;
				end
				S_POP: begin
					if (head_q == tail_q) begin
						max_q   <= flow_q;
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					u_q     <= sq_rd_q;
					i_q     <= '0;
					state_q <= S_SCAN_RD;
				end
				S_SCAN_RD: begin
					if (NCNT_W'(i_q) == eff_n) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					i_q <= i_q + 1'b1;
					if (!visited_q[iv] && (mem_rd_q != '0)) begin
						visited_q[iv] <= 1'b1;
						if (iv == dst_n) begin
							v_q     <= dst_n;
							bott_q  <= '1;
							state_q <= S_WALK_P;
						end else begin
							state_q <= S_SCAN_RD;
							if (tail_q < CW'(MAX_NODES)) begin
								tail_q <= tail_q + 1'b1;
							end
						end
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_WALK_P: begin
					if (v_q == src_n) begin
						v_q     <= dst_n;
						state_q <= S_AUG_P;
					end else begin
						state_q <= S_WALK_M;
					end
				end
				S_WALK_M: begin
					u_q     <= pred_rd_q;
					state_q <= S_WALK_C;
				end
				S_WALK_C: begin
					if (mem_rd_q < bott_q) begin
						bott_q <= mem_rd_q;
					end
					v_q     <= u_q;
					state_q <= S_WALK_P;
				end
				S_AUG_P: begin
					if (v_q == src_n) begin
						flow_q  <= flow_q + FLOW_W'(bott_q);
						state_q <= S_BFS_INIT;
					end else begin
						state_q <= S_AUG_M;
					end
				end
				S_AUG_M: begin
					u_q     <= pred_rd_q;
					state_q <= S_AUG_F;
				end
				S_AUG_F: begin
					state_q <= S_AUG_B;
				end
				S_AUG_B: begin
					v_q     <= u_q;
					state_q <= S_AUG_P;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for max_flow_edmonds_karp_unit. A directed table of
// register writes and edges runs first, then random graphs with random
// settings. Totals are checked against table values or an in-bench solver.
// ----------------------------------------------------------------------------
module testbench;
	import edk_pkg::*;

	localparam int NODES = 128;

	typedef struct {
		bit               is_cfg;
		logic [1:0]       idx;
		logic [7:0]       data;
		logic [6:0]       src_n;
		logic [6:0]       dst_n;
		logic [CAP_W-1:0] cap;
		bit               last;
		int               flow;
	} step_t;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                start = 0;
	logic                busy;
	logic [NODE_FW-1:0]  from_node = '0;
	logic [NODE_FW-1:0]  to_node = '0;
	logic [CAP_W-1:0]    capacity = '0;
	logic                last_edge = 0;
	logic [FLOW_W-1:0]   max_flow;
	logic                done;
	logic                cfg_valid = 0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [7:0]          cfg_data = '0;

	logic [RES_W-1:0]    resid [NODES][NODES];
	logic [7:0]          node_cnt = 8'd128;
	logic [6:0]          src_reg = 7'd0;
	logic [6:0]          sink_reg = 7'd127;
	logic [FLOW_W-1:0]   flow_q [$];
	int                  typed_flow = -1;
	int                  edges_taken = 0;
	int                  cfg_taken = 0;
	int                  flows_seen = 0;
	int                  errors = 0;
	int                  no_idle_lo = 0;
	int                  no_idle_hi = 0;
	step_t               plan [$];

	max_flow_edmonds_karp_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.from_node(from_node), .to_node(to_node), .capacity(capacity),
		.last_edge(last_edge), .max_flow(max_flow), .done(done),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	function automatic void clear_resid();
		foreach (resid[i, j]) resid[i][j] = '0;
	endfunction

	function automatic logic [FLOW_W-1:0] solve_flow();
		int n;
		int pred [NODES];
		bit seen [NODES];
		int fifo [NODES];
		int head, tail, u, v;
		bit found;
		logic [RES_W-1:0] neck;
		logic [FLOW_W-1:0] total;
		n = (node_cnt > NODES) ? NODES : node_cnt;
		total = '0;
		if (n < 2 || src_reg >= n || sink_reg >= n || src_reg == sink_reg)
			return '0;
		forever begin
			foreach (seen[i]) seen[i] = 0;
			seen[src_reg] = 1;
			pred[src_reg] = src_reg;
			head = 0;
			tail = 1;
			fifo[0] = src_reg;
			found = 0;
			while (head < tail && !found) begin
				u = fifo[head];
				head++;
				for (int i = 0; i < n && !found; i++) begin
					if (!seen[i] && resid[u][i] != 0) begin
						seen[i] = 1;
						pred[i] = u;
						if (i == sink_reg) found = 1;
						else if (tail < NODES) begin
							fifo[tail] = i;
							tail++;
						end
					end
				end
			end
			if (!found) return total;
			neck = '1;
			for (v = sink_reg; v != src_reg; v = pred[v])
				if (resid[pred[v]][v] < neck) neck = resid[pred[v]][v];
			for (v = sink_reg; v != src_reg; v = pred[v]) begin
				resid[pred[v]][v] -= neck;
				resid[v][pred[v]] += neck;
			end
			total += FLOW_W'(neck);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_NODE_COUNT: node_cnt <= cfg_data;
					CFG_SOURCE:     src_reg <= cfg_data[6:0];
					CFG_SINK:       sink_reg <= cfg_data[6:0];
					default: ;
				endcase
				cfg_taken++;
			end
			if (start && !busy) begin
				edges_taken++;
				if (from_node < ((node_cnt > NODES) ? NODES : node_cnt) &&
				    to_node < ((node_cnt > NODES) ? NODES : node_cnt))
					resid[from_node][to_node] = {1'b0, capacity};
				if (last_edge) begin
					if (typed_flow >= 0) begin
						flow_q.push_back(typed_flow[FLOW_W-1:0]);
						void'(solve_flow());
					end else
						flow_q.push_back(solve_flow());
					clear_resid();
				end
			end
			if (done) begin
				flows_seen++;
				if (flow_q.size() == 0) begin
					$display("%0t: unexpected max_flow %0d", $time, max_flow);
					errors++;
				end else begin
					if (max_flow !== flow_q[0]) begin
						$display("%0t: max_flow expected %0d actual %0d",
						         $time, flow_q[0], max_flow);
						errors++;
					end
					void'(flow_q.pop_front());
				end
			end
		end
	end

	task automatic idle_gap();
		if (!(edges_taken >= no_idle_lo && edges_taken < no_idle_hi))
			while ($urandom_range(0, 99) < 13) begin
				start <= 0;
				cfg_valid <= 0;
				@(negedge clk);
			end
	endtask

	task automatic settle();
		start <= 0;
		while (flow_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		while (busy) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		int mark;
		settle();
		idle_gap();
		mark = cfg_taken;
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(negedge clk); while (cfg_taken == mark);
		cfg_valid <= 0;
	endtask

	task automatic send_edge(input logic [6:0] f, input logic [6:0] t,
	                         input logic [CAP_W-1:0] c, input bit l, input int flow);
		int mark;
		idle_gap();
		mark = edges_taken;
		from_node <= f;
		to_node <= t;
		capacity <= c;
		last_edge <= l;
		typed_flow <= flow;
		start <= 1;
		do @(negedge clk); while (edges_taken == mark);
	endtask

	task automatic add_cfg(input logic [1:0] idx, input logic [7:0] val);
		step_t s;
		s = '{1, idx, val, 0, 0, 0, 0, -1};
		plan.push_back(s);
	endtask

	task automatic add_edge(input logic [6:0] f, input logic [6:0] t,
	                        input logic [CAP_W-1:0] c, input bit l, input int flow);
		step_t s;
		s = '{0, CFG_NODE_COUNT, 0, f, t, c, l, flow};
		plan.push_back(s);
	endtask

	initial begin
		int n, e, graphs, f, t;
		logic [CAP_W-1:0] c;
		add_edge(7'd0, 7'd127, 16'hFFFF, 1, 65535);
		add_edge(7'd127, 7'd0, 16'hFFFF, 0, -1);
		add_edge(7'd0, 7'd127, 16'd5, 0, -1);
		add_edge(7'd0, 7'd127, 16'd9, 1, 9);
		add_cfg(CFG_NODE_COUNT, 8'd4);
		add_cfg(CFG_SINK, 8'd3);
		add_edge(7'd0, 7'd1, 16'd10, 0, -1);
		add_edge(7'd1, 7'd3, 16'd4, 0, -1);
		add_edge(7'd0, 7'd2, 16'd3, 0, -1);
		add_edge(7'd2, 7'd3, 16'd8, 0, -1);
		add_edge(7'd1, 7'd2, 16'd6, 0, -1);
		add_edge(7'd0, 7'd3, 16'd0, 0, -1);
		add_edge(7'd5, 7'd3, 16'd100, 1, -1);
		add_cfg(CFG_SOURCE, 8'd3);
		add_edge(7'd3, 7'd3, 16'd7, 1, 0);
		add_cfg(CFG_SOURCE, 8'd127);
		add_edge(7'd0, 7'd3, 16'd7, 1, 0);
		add_cfg(CFG_SOURCE, 8'd0);
		add_cfg(CFG_NODE_COUNT, 8'd1);
		add_edge(7'd0, 7'd0, 16'd7, 1, 0);
		add_cfg(CFG_NODE_COUNT, 8'd255);
		add_cfg(CFG_SINK, 8'd255);
		add_edge(7'd0, 7'd127, 16'd1, 1, 1);
		add_cfg(CFG_NODE_COUNT, 8'd2);
		add_cfg(CFG_SINK, 8'd1);
		add_edge(7'd0, 7'd1, 16'hFFFF, 1, 65535);

		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (plan[i])
			if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].data);
			else send_edge(plan[i].src_n, plan[i].dst_n, plan[i].cap, plan[i].last,
			               plan[i].flow);

		no_idle_lo = edges_taken + 600;
		no_idle_hi = edges_taken + 900;
		graphs = 0;
		while (edges_taken < 1800 || graphs < 40) begin
			if ($urandom_range(0, 2) == 0 || graphs == 0) begin
				case ($urandom_range(0, 9))
					0: n = 128;
					1: n = $urandom_range(2, 127);
					default: n = $urandom_range(2, 10);
				endcase
				if ($urandom_range(0, 19) == 0)
					write_reg(CFG_NODE_COUNT, 8'($urandom_range(0, 255)));
				else
					write_reg(CFG_NODE_COUNT, 8'(n));
				f = $urandom_range(0, n - 1);
				do t = $urandom_range(0, n - 1); while (t == f && $urandom_range(0, 9) != 0);
				write_reg(CFG_SOURCE, {1'($urandom_range(0, 1)), 7'(f)});
				write_reg(CFG_SINK, {1'($urandom_range(0, 1)), 7'(t)});
			end
			n = (node_cnt > NODES) ? NODES : ((node_cnt < 2) ? 2 : node_cnt);
			e = (n > 16) ? $urandom_range(1, 20) : $urandom_range(1, 35);
			for (int k = 0; k < e; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					f = $urandom_range(0, 127);
					t = $urandom_range(0, 127);
				end else begin
					f = $urandom_range(0, n - 1);
					t = $urandom_range(0, n - 1);
				end
				case ($urandom_range(0, 9))
					0: c = 16'h0000;
					1: c = 16'hFFFF;
					2: c = 16'($urandom_range(0, 65535));
					default: c = 16'($urandom_range(1, 50));
				endcase
				send_edge(7'(f), 7'(t), c, k == e - 1, -1);
			end
			graphs++;
		end
		start <= 0;

		fork
			begin
				while (flow_q.size() != 0) @(posedge clk);
				repeat (200) @(posedge clk);
			end
		join
		$display("Edges sent: %0d, register writes: %0d, flow totals checked: %0d",
		         edges_taken, cfg_taken, flows_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		clear_resid();
		#400_000_000;
		$display("Timeout with %0d flow totals outstanding", flow_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
